// File: design/assert_macros.svh
// assertion helpers used by the scanner rtl
// both sample on clk and are disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: design/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Constants and register map for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

	localparam int PAT_BYTES = 16;
	localparam int LEN_W     = 5;
	localparam int WILD_W    = 8;
	localparam int CFG_DW    = 64;
	localparam int CFG_AW    = 6;
	localparam int REG_IDX_W = 3;
	localparam int ADDR_W    = 64;

	localparam logic [WILD_W-1:0] WILDCARD_RESET = 8'hCC;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PAT_LO   = 3'd0,
		REG_PAT_HI   = 3'd1,
		REG_PAT_LEN  = 3'd2,
		REG_WILDCARD = 3'd3,
		REG_BASE     = 3'd4
	} reg_idx_t;

endpackage

`default_nettype wire

// File: design/wildcard_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Streams a region byte by byte through a sliding window and reports the
// address of the first wildcard pattern match, or not-found at region end.
// ----------------------------------------------------------------------------
// results are registered, in the output register or, while it stalls, in the skid register
// throughput: one byte per cycle while in_stall is low; the compare is combinational
// an output register plus a skid register keep input flowing while one result waits
// in_stall rises only while both result registers are full
// reset: asynchronous, clears region state, handshake state and config registers
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wildcard_byte_pattern_scan
	import wbps_pkg::*;
#(
	parameter int MAX_PATTERN = 16,
	parameter int COUNT_BITS  = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_AW-1:0]     paddr,
	input  wire logic [CFG_DW-1:0]     pwdata,
	output logic      [CFG_DW-1:0]     prdata,
	output logic                       pready,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  last_byte,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       found,
	output logic      [ADDR_W-1:0]     match_address
);

	localparam int CAP   = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
	localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;

	// configuration registers
	logic [CFG_DW-1:0] pat_lo_q;
	logic [CFG_DW-1:0] pat_hi_q;
	logic [LEN_W-1:0]  pat_len_q;
	logic [WILD_W-1:0] wild_q;
	logic [ADDR_W-1:0] base_q;
	logic              cfg_wr;

	// region state
	logic [7:0]            win_q [CAP];
	logic [7:0]            win_nx [CAP];
	logic [COUNT_BITS-1:0] bytes_seen_q;
	logic                  reported_q;

	// result registers
	logic              out_valid_q;
	logic              out_found_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic              skid_valid_q;
	logic              skid_found_q;
	logic [ADDR_W-1:0] skid_addr_q;

	logic                  acc;
	logic                  out_fire;
	logic [LEN_W-1:0]      len_eff;
	logic [LEN_W-1:0]      len_m1;
	logic [2*CFG_DW-1:0]   pat_all;
	logic                  sat;
	logic                  hit_all;
	logic                  hit;
	logic                  res_valid;
	logic [ADDR_W-1:0]     res_addr;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= LEN_W'(1);
			wild_q    <= WILDCARD_RESET;
			base_q    <= '0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[CFG_AW-1:3]))
				REG_PAT_LO:   pat_lo_q  <= pwdata;
				REG_PAT_HI:   pat_hi_q  <= pwdata;
				REG_PAT_LEN:  pat_len_q <= pwdata[LEN_W-1:0];
				REG_WILDCARD: wild_q    <= pwdata[WILD_W-1:0];
				REG_BASE:     base_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[CFG_AW-1:3]))
			REG_PAT_LO:   prdata = pat_lo_q;
			REG_PAT_HI:   prdata = pat_hi_q;
			REG_PAT_LEN:  prdata = CFG_DW'(pat_len_q);
			REG_WILDCARD: prdata = CFG_DW'(wild_q);
			REG_BASE:     prdata = base_q;
			default:      prdata = '0;
		endcase
	end

	// effective pattern length
	always_comb begin
		if (pat_len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (pat_len_q > LEN_W'(CAP)) begin
			len_eff = LEN_W'(CAP);
		end else begin
			len_eff = pat_len_q;
		end
	end

	assign len_m1  = len_eff - LEN_W'(1);
	assign pat_all = {pat_hi_q, pat_lo_q};

	// window after shifting in this beat, entry 0 newest
	always_comb begin
		win_nx[0] = data_byte;
		for (int j = 1; j < CAP; j++) begin
			win_nx[j] = win_q[j-1];
		end
	end

	// wildcard compare
	always_comb begin
		logic [LEN_W-1:0] k;
		logic [7:0]       pb;
		hit_all = 1'b1;
		k       = '0;
		pb      = '0;
		for (int i = 0; i < CAP; i++) begin
			k  = len_m1 - LEN_W'(i);
			pb = pat_all[8*i +: 8];
			if ((LEN_W'(i) < len_eff) && (pb != wild_q) && (pb != win_nx[k[IDX_W-1:0]])) begin
				hit_all = 1'b0;
			end
		end
	end

	assign sat       = (bytes_seen_q == '1);
	assign hit       = !sat && (bytes_seen_q >= COUNT_BITS'(len_m1)) && hit_all;
	assign res_valid = !reported_q && (hit || last_byte);
	assign res_addr  = hit ? (base_q + ADDR_W'(bytes_seen_q) - ADDR_W'(len_m1)) : '0;

	// handshake
	assign in_stall = skid_valid_q;
	assign acc      = in_valid && !in_stall;
	assign out_fire = out_valid_q && !out_stall;

	// region state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			reported_q   <= 1'b0;
		end else if (acc) begin
			if (last_byte) begin
				bytes_seen_q <= '0;
				reported_q   <= 1'b0;
			end else begin
				if (!sat) begin
					bytes_seen_q <= bytes_seen_q + COUNT_BITS'(1);
				end
				reported_q <= reported_q | hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < CAP; j++) begin
				win_q[j] <= '0;
			end
		end else if (acc) begin
			for (int j = 0; j < CAP; j++) begin
				win_q[j] <= win_nx[j];
			end
		end
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (acc && res_valid) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_found_q <= skid_found_q;
				out_addr_q  <= skid_addr_q;
			end
		end else if (acc && res_valid) begin
			if (!out_valid_q || out_fire) begin
				out_found_q <= hit;
				out_addr_q  <= res_addr;
			end else begin
				skid_found_q <= hit;
				skid_addr_q  <= res_addr;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = out_found_q;
	assign match_address = out_addr_q;

	`ASSERT_SAME(a_skid_needs_out, skid_valid_q, out_valid_q)
	`ASSERT_NEXT(a_region_clears, acc && last_byte, (bytes_seen_q == '0) && !reported_q)
	`ASSERT_SAME(a_quiet_after_match, acc && reported_q, !res_valid)
	`ASSERT_NEXT(a_match_marks, acc && hit && !reported_q && !last_byte, reported_q)

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wildcard byte pattern scanner. Byte regions are
// streamed in under random idling and back-pressure, a behavioural copy of the
// scanner predicts each match or not-found beat, and every output beat is
// compared field by field against the oldest prediction. The register set is
// rewritten between phases, covering length and wildcard extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import wbps_pkg::*;

	localparam int WATCHDOG_CYCLES = 2000;
	localparam int HOLD_CYCLES     = 200;
	localparam int SETTLE_CYCLES   = 8;
	localparam int NUM_PHASES      = 18;
	localparam int PHASE_ITEMS     = 58;
	localparam int STEADY_ITEMS    = 250;
	localparam int MAX_REPORTS     = 30;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] addr;
	} scan_result_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [CFG_AW-1:0]   paddr;
	logic [CFG_DW-1:0]   pwdata;
	logic [CFG_DW-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_stall;
	logic [7:0]          data_byte;
	logic                last_byte;
	logic                out_valid;
	logic                out_stall;
	logic                found;
	logic [ADDR_W-1:0]   match_address;

	// scanner copy: registers and region state
	logic [63:0]  pat_lo = '0;
	logic [63:0]  pat_hi = '0;
	logic [LEN_W-1:0] pat_len = 5'd1;
	logic [WILD_W-1:0] wild = WILDCARD_RESET;
	logic [63:0]  base = '0;
	logic [7:0]   win [PAT_BYTES] = '{default: '0};
	logic [31:0]  seen = '0;
	bit           reported = 1'b0;

	scan_result_t pending_results [$];

	bit no_idle = 1'b0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	int n_items = 0;
	int n_regions = 0;
	int n_hits = 0;
	int n_misses = 0;
	int n_writes = 0;
	int n_settings = 0;
	int n_errors = 0;

	wildcard_byte_pattern_scan dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.found         (found),
		.match_address (match_address)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int live_length();
		int len;
		len = int'(pat_len);
		if (len < 1)
			len = 1;
		if (len > PAT_BYTES)
			len = PAT_BYTES;
		return len;
	endfunction

	function automatic bit scan_step(input logic [7:0] value, input logic last,
			output scan_result_t res);
		int len, i;
		bit sat, hit, ok;
		logic [127:0] pat;
		logic [7:0] p;
		len = live_length();
		pat = {pat_hi, pat_lo};
		sat = (seen == '1);
		for (i = PAT_BYTES - 1; i > 0; i--)
			win[i] = win[i-1];
		win[0] = value;
		if (!sat)
			seen++;
		hit = 1'b0;
		res = '0;
		if (!reported) begin
			ok = !sat && (int'(seen) >= len);
			for (i = 0; i < len; i++) begin
				p = pat[8*i +: 8];
				if (p != wild && p != win[len-1-i])
					ok = 1'b0;
			end
			if (ok) begin
				res.found = 1'b1;
				res.addr = base + (64'(seen) - 64'(len));
				reported = 1'b1;
				hit = 1'b1;
			end else if (last) begin
				hit = 1'b1;
			end
		end
		if (last) begin
			foreach (win[k])
				win[k] = '0;
			seen = '0;
			reported = 1'b0;
		end
		return hit;
	endfunction

	task automatic push_byte(input logic [7:0] value, input logic last);
		scan_result_t res;
		while (!no_idle && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= value;
		last_byte <= last;
		do @(posedge clk); while (in_stall);
		n_items++;
		if (last)
			n_regions++;
		if (scan_step(value, last, res))
			pending_results.push_back(res);
	endtask

	task automatic send_region(input logic [7:0] stream [$]);
		foreach (stream[j])
			push_byte(stream[j], j == stream.size() - 1);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_PAT_LO: pat_lo = value;
			REG_PAT_HI: pat_hi = value;
			REG_PAT_LEN: pat_len = value[LEN_W-1:0];
			REG_WILDCARD: wild = value[WILD_W-1:0];
			REG_BASE: base = value;
			default: ;
		endcase
		n_writes++;
		@(posedge clk);
	endtask

	task automatic configure_phase(input int phase);
		logic [127:0] pat;
		logic [7:0] w, b;
		logic [LEN_W-1:0] len;
		logic [63:0] addr;
		int r, i;
		case (phase % 7)
			0: len = 5'd1;
			1: len = 5'd16;
			2: len = 5'd0;
			3: len = 5'd31;
			4: len = 5'($urandom_range(17, 30));
			default: len = 5'($urandom_range(2, 15));
		endcase
		case (phase % 4)
			0: w = 8'h00;
			1: w = 8'hFF;
			2: w = WILDCARD_RESET;
			default: w = 8'($urandom);
		endcase
		case (phase % 3)
			0: addr = '0;
			1: addr = '1;
			default: addr = {$urandom, $urandom};
		endcase
		for (i = 0; i < PAT_BYTES; i++) begin
			r = $urandom_range(99);
			if (r < 20)
				b = w;
			else if (r < 30)
				b = 8'h00;
			else if (r < 40)
				b = 8'hFF;
			else
				b = 8'($urandom);
			pat[8*i +: 8] = b;
		end
		cfg_write(REG_WILDCARD, 64'(w));
		cfg_write(REG_PAT_LO, pat[63:0]);
		cfg_write(REG_PAT_HI, pat[127:64]);
		cfg_write(REG_PAT_LEN, 64'(len));
		cfg_write(REG_BASE, addr);
		n_settings++;
	endtask

	// mostly regions with a planted pattern, some cut off by the region end
	task automatic random_region();
		logic [7:0] stream [$];
		logic [127:0] pat;
		logic [7:0] b;
		int span, len, start, roll, i, k;
		pat = {pat_hi, pat_lo};
		len = live_length();
		span = ($urandom_range(9) == 0) ? int'($urandom_range(25, 48))
				: int'($urandom_range(1, 24));
		for (i = 0; i < span; i++) begin
			k = int'($urandom_range(len - 1));
			if ($urandom_range(1))
				stream.push_back(pat[8*k +: 8]);
			else
				stream.push_back(8'($urandom));
		end
		roll = int'($urandom_range(99));
		if (roll < 60 && span >= len)
			start = int'($urandom_range(span - len));
		else
			start = span - len + int'($urandom_range(1, len));
		if (roll < 75) begin
			for (i = 0; i < len; i++) begin
				if (start + i >= 0 && start + i < span) begin
					b = pat[8*i +: 8];
					if (b == wild)
						b = 8'($urandom);
					stream[start+i] = b;
				end
			end
		end
		send_region(stream);
	endtask

	task automatic test_reset_state();
		logic [7:0] stream [$];
		stream = {8'hFF};
		send_region(stream);
		stream = {8'h00};
		send_region(stream);
		settle();
	endtask

	task automatic test_directed();
		logic [7:0] stream [$];
		cfg_write(REG_WILDCARD, 64'(WILDCARD_RESET));
		cfg_write(REG_PAT_LO, 64'h0000_0000_FF00_CCA5);
		cfg_write(REG_PAT_HI, '1);
		cfg_write(REG_PAT_LEN, 64'd4);
		cfg_write(REG_BASE, '1);
		// match on the last beat, address wraps
		stream = {8'h00, 8'hA5, 8'h77, 8'h00, 8'hFF};
		send_region(stream);
		// region shorter than the pattern
		stream = {8'hA5, 8'hCC};
		send_region(stream);
		// beats after a match stay silent
		stream = {8'hA5, 8'h01, 8'h00, 8'hFF, 8'h00, 8'hFF};
		send_region(stream);
		// length change inside a region keeps the window
		push_byte(8'h11, 1'b0);
		push_byte(8'hA5, 1'b0);
		settle();
		cfg_write(REG_PAT_LEN, 64'd2);
		push_byte(8'h42, 1'b0);
		push_byte(8'h07, 1'b1);
		settle();
	endtask

	task automatic test_random_phases();
		int p, start;
		for (p = 0; p < NUM_PHASES; p++) begin
			configure_phase(p);
			start = n_items;
			while (n_items - start < PHASE_ITEMS)
				random_region();
			settle();
		end
	endtask

	task automatic test_backpressure();
		int i;
		cfg_write(REG_PAT_LEN, 64'd1);
		cfg_write(REG_PAT_LO, 64'h5A);
		cfg_write(REG_WILDCARD, 64'h33);
		hold_request = 1'b1;
		for (i = 0; i < 40; i++)
			push_byte($urandom_range(1) ? 8'h5A : 8'($urandom), 1'b1);
		settle();
	endtask

	task automatic test_steady_stream();
		int start;
		configure_phase(5);
		no_idle = 1'b1;
		start = n_items;
		while (n_items - start < STEADY_ITEMS)
			random_region();
		settle();
		no_idle = 1'b0;
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !no_idle && ($urandom_range(99) < 29);
			end
		end
	end

	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("%0t unexpected beat: expected none, actual found %0b address %h",
						$time, found, match_address);
			end else begin
				want = pending_results.pop_front();
				if (found !== want.found) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("%0t found mismatch: expected %0b actual %0b",
							$time, want.found, found);
				end
				if (match_address !== want.addr) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("%0t match_address mismatch: expected %h actual %h",
							$time, want.addr, match_address);
				end
				if (want.found)
					n_hits++;
				else
					n_misses++;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t watchdog: no beat for %0d cycles", $time, WATCHDOG_CYCLES);
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		data_byte <= '0;
		last_byte <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed();
		test_random_phases();
		test_backpressure();
		test_steady_stream();
		settle();
		if (pending_results.size() != 0) begin
			n_errors++;
			$display("%0t %0d predicted beats never arrived", $time, pending_results.size());
		end
		$display("tb: %0d bytes in %0d regions, %0d matches and %0d not-found beats checked",
			n_items, n_regions, n_hits, n_misses);
		$display("tb: %0d register writes over %0d random settings, %0d mismatches",
			n_writes, n_settings, n_errors);
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
